>>> sv/sha1he_pkg.sv
// ---------------------------------------------------------------------------
// SHA-1 hash engine package
// Word type, initial chaining values, round constants and sequencing limits
// used by the SHA-1 hash engine.
// ---------------------------------------------------------------------------
package sha1he_pkg;

  // One 32-bit SHA-1 word.
  typedef logic [31:0] word_t;

  // Standard initial chaining values H0 to H4.
  localparam word_t H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one for each group of twenty rounds.
  localparam word_t K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  // Round counter limits within one 64-byte block.
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_G1   = 7'd20;
  localparam logic [6:0] ROUND_G2   = 7'd40;
  localparam logic [6:0] ROUND_G3   = 7'd60;

  // Byte position in a block at which the length field starts (448 bits).
  localparam logic [5:0] LEN_POS = 6'd56;

  // Bit length at which a further byte overflows the 64-bit length field.
  localparam logic [63:0] MAX_BIT_LEN = 64'hFFFF_FFFF_FFFF_FFF8;

  // Padding marker byte and the number of the last digest word.
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [2:0] WORD_LAST = 3'd4;

endpackage

>>> sv/sha1_hash_engine.sv
// ---------------------------------------------------------------------------
// SHA-1 hash engine
// Takes a message at most one byte per request and returns its SHA-1 digest as five
// 32-bit words, h0 first. A single round unit is reused for all 80 rounds.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | tdata           | tlast          | tuser
//  ---------+-----------+-----------------+----------------+----------------
//  s_axis   | in        | data_byte [7:0] | end_of_message | byte_present
//  m_axis   | out       | digest_word     | last_word      | length_overflow
//
// A byte request that neither completes a 64-byte block nor ends the message
// leaves the input ready. A byte that completes a block is followed by the
// shared round unit's rounds, then the chaining update. End of message pads
// one byte per cycle, pausing for each block compression (up to 72 bytes and
// two compressions), then offers the five digest words, one per accepted beat.
// Reset is asynchronous and active low; it clears control state and restores
// the initial chaining values at once. Input is not ready while busy.
//
module sha1_hash_engine
  import sha1he_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  input  logic        s_axis_tuser,   // [0] byte_present
  // Digest word stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast,   // last_word
  output logic        m_axis_tuser    // [0] length_overflow
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_MARK,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } phase_e;

  state_e      state_q;
  phase_e      phase_q;
  logic [6:0]  round_q;
  logic [5:0]  blk_cnt_q;
  logic [2:0]  len_idx_q;
  logic [2:0]  out_idx_q;
  logic [63:0] bit_len_q;
  logic        ovf_q;
  word_t       chain_q [5];
  word_t       work_q  [5];
  word_t       sched_q [16];
  logic [23:0] asm_q;

  logic        s_fire;
  logic        m_fire;
  logic        push_en;
  logic [7:0]  push_byte;
  logic [5:0]  cnt_nx;
  logic        blk_done;
  logic [5:0]  len_sel;
  word_t       f_val;
  word_t       k_val;
  word_t       temp;
  word_t       w_new;

  // Handshakes.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  // Digest word offered from the chaining register selected by the word count.
  assign m_axis_tdata = chain_q[out_idx_q];
  assign m_axis_tlast = (out_idx_q == WORD_LAST);
  assign m_axis_tuser = ovf_q;

  // Byte push path, shared by message bytes and padding bytes.
  assign len_sel = {3'(3'd7 - len_idx_q), 3'b000};

  always_comb begin
    push_en   = 1'b0;
    push_byte = s_axis_tdata;
    if (state_q == ST_IDLE) begin
      push_en = s_fire && s_axis_tuser;
    end else if (state_q == ST_PAD) begin
      push_en = 1'b1;
      unique case (phase_q)
        PH_MARK: push_byte = PAD_MARK;
        PH_LEN:  push_byte = bit_len_q[len_sel +: 8];
        default: push_byte = 8'h00;
      endcase
    end
  end

  assign cnt_nx   = blk_cnt_q + 6'd1;
  assign blk_done = push_en && (cnt_nx == 6'd0);

  // Round function and constant for the current round.
  always_comb begin
    priority if (round_q < ROUND_G1) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = K_ROUND[0];
    end else if (round_q < ROUND_G2) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K_ROUND[1];
    end else if (round_q < ROUND_G3) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) |
              (work_q[2] & work_q[3]);
      k_val = K_ROUND[2];
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K_ROUND[3];
    end
  end

  // The window holds W[t] to W[t+15]; the word shifted in is W[t+16].
  assign temp  = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + k_val +
                 sched_q[0];
  assign w_new = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];

  // Sequencer, counters, length tracking and chaining values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_NONE;
      round_q   <= '0;
      blk_cnt_q <= '0;
      len_idx_q <= '0;
      out_idx_q <= '0;
      bit_len_q <= '0;
      ovf_q     <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= H_INIT[i];
      end
    end else begin
      if (push_en) begin
        blk_cnt_q <= cnt_nx;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_axis_tuser) begin
              if (bit_len_q == MAX_BIT_LEN) begin
                ovf_q <= 1'b1;
              end
              bit_len_q <= bit_len_q + 64'd8;
            end
            if (blk_done) begin
              state_q <= ST_ROUND;
              round_q <= '0;
              phase_q <= s_axis_tlast ? PH_MARK : PH_NONE;
            end else if (s_axis_tlast) begin
              state_q <= ST_PAD;
              phase_q <= PH_MARK;
            end
          end
        end
        ST_ROUND: begin
          round_q <= round_q + 7'd1;
          if (round_q == ROUND_LAST) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 5; i++) begin
            chain_q[i] <= chain_q[i] + work_q[i];
          end
          unique case (phase_q)
            PH_NONE: state_q <= ST_IDLE;
            PH_DONE: begin
              state_q   <= ST_OUT;
              out_idx_q <= '0;
            end
            default: state_q <= ST_PAD;
          endcase
        end
        ST_PAD: begin
          unique case (phase_q)
            PH_MARK: phase_q <= (cnt_nx == LEN_POS) ? PH_LEN : PH_ZERO;
            PH_ZERO: begin
              if (cnt_nx == LEN_POS) begin
                phase_q <= PH_LEN;
              end
            end
            PH_LEN: begin
              len_idx_q <= len_idx_q + 3'd1;
              if (len_idx_q == 3'd7) begin
                phase_q <= PH_DONE;
              end
            end
            default: phase_q <= PH_DONE;
          endcase
          if (blk_done) begin
            state_q <= ST_ROUND;
            round_q <= '0;
          end
        end
        ST_OUT: begin
          if (m_fire) begin
            out_idx_q <= out_idx_q + 3'd1;
            if (out_idx_q == WORD_LAST) begin
              state_q   <= ST_IDLE;
              phase_q   <= PH_NONE;
              len_idx_q <= '0;
              bit_len_q <= '0;
              ovf_q     <= 1'b0;
              for (int i = 0; i < 5; i++) begin
                chain_q[i] <= H_INIT[i];
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Word assembly, message schedule window and working values.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      if (cnt_nx[1:0] == 2'b00) begin
        for (int i = 0; i < 15; i++) begin
          sched_q[i] <= sched_q[i+1];
        end
        sched_q[15] <= {asm_q, push_byte};
        asm_q       <= '0;
      end else begin
        asm_q <= {asm_q[15:0], push_byte};
      end
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[15] <= {w_new[30:0], w_new[31]};
    end

    // Working values load from the chain when a block fills, then one round a cycle.
    if (blk_done) begin
      for (int i = 0; i < 5; i++) begin
        work_q[i] <= chain_q[i];
      end
    end else if (state_q == ST_ROUND) begin
      work_q[4] <= work_q[3];
      work_q[3] <= work_q[2];
      work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
      work_q[1] <= work_q[0];
      work_q[0] <= temp;
    end
  end

`ifndef SYNTHESIS
  // The input side is never open while a digest word is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a digest word is pending");

  // Rounds stay within one block's 80 rounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (round_q <= ROUND_LAST))
    else $error("round counter beyond the last round");

  // Digest words are offered only on a block boundary after the length field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (blk_cnt_q == 6'd0) && (phase_q == PH_DONE))
    else $error("digest offered before padding finished");

  // The last digest word hands back to the input side at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("engine not ready after the last digest word");
`endif

endmodule

>>> tb/sv/sha1_digest_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SHA-1 digest checker
// Watches the byte stream and the digest stream of the SHA-1 hash engine.
// It keeps its own running SHA-1 state, computes each digest when a message
// ends, and compares every digest word that the engine returns with it.
// ---------------------------------------------------------------------------
module sha1_digest_checker
  import sha1he_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream, as seen at the engine's input.
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        in_user_i,
  // Digest stream, as seen at the engine's output.
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,
  input  logic        out_last_i,
  input  logic        out_user_i,
  // Digest words still owed by the engine, and the number of mismatches.
  output int          pending_words_o,
  output int          mismatch_count_o
);

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        ovf;
  } digest_beat_t;

  // Running hash state of the current message.
  word_t       chain_h [5];
  word_t       sched_w [16];
  logic [31:0] word_acc;
  logic [5:0]  blk_pos;
  logic [63:0] bit_len;
  logic        ovf_seen;

  // Digest words computed but not yet returned by the engine.
  digest_beat_t digest_q [$];

  function automatic word_t rol(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: digest mismatch on %s: got %08h, expected %08h",
             $time, what, got, want);
    mismatch_count_o++;
  endtask

  task automatic clear_state();
    for (int i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
    word_acc = '0;
    blk_pos  = '0;
    bit_len  = '0;
    ovf_seen = 1'b0;
  endtask

  // Eighty rounds over the current schedule window, then the chaining update.
  task automatic compress_block();
    word_t a, b, c, d, e, f, w, t;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w = sched_w[(r - 3) & 15] ^ sched_w[(r - 8) & 15] ^
            sched_w[(r - 14) & 15] ^ sched_w[r & 15];
        sched_w[r & 15] = rol(w, 1);
      end
      w = sched_w[r & 15];
      if (r < 20)      f = (b & c) | (~b & d);
      else if (r < 40) f = b ^ c ^ d;
      else if (r < 60) f = (b & c) | (b & d) | (c & d);
      else             f = b ^ c ^ d;
      t = rol(a, 5) + f + e + K_ROUND[r / 20] + w;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  // Big-endian word packing; a full block triggers compression.
  task automatic absorb_byte(input logic [7:0] b);
    logic [5:0] slot;
    word_acc = {word_acc[23:0], b};
    blk_pos  = blk_pos + 6'd1;
    if (blk_pos[1:0] == 2'd0) begin
      slot = blk_pos - 6'd1;
      sched_w[slot[5:2]] = word_acc;
      word_acc = '0;
    end
    if (blk_pos == 6'd0) compress_block();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t want;
    logic [63:0]  len_snap;
    if (!rst_ni) begin
      clear_state();
      digest_q.delete();
      pending_words_o <= 0;
      mismatch_count_o = 0;
    end else begin
      // Compare each returned digest word with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t ns: digest word %08h returned with none outstanding",
                   $time, out_data_i);
          mismatch_count_o++;
        end else begin
          want = digest_q.pop_front();
          if (out_data_i !== want.word) report_mismatch("word", out_data_i, want.word);
          if (out_last_i !== want.last) begin
            report_mismatch("last", 32'(out_last_i), 32'(want.last));
          end
          if (out_user_i !== want.ovf) begin
            report_mismatch("overflow", 32'(out_user_i), 32'(want.ovf));
          end
        end
      end

      // Advance the hash state with each accepted byte request.
      if (in_valid_i && in_ready_i) begin
        if (in_user_i) begin
          if (bit_len == MAX_BIT_LEN) ovf_seen = 1'b1;
          bit_len = bit_len + 64'd8;
          absorb_byte(in_data_i);
        end
        if (in_last_i) begin
          // Padding: marker byte, zeros up to the length field, then the length.
          len_snap = bit_len;
          absorb_byte(PAD_MARK);
          while (blk_pos != LEN_POS) absorb_byte(8'h00);
          for (int i = 0; i < 8; i++) absorb_byte(len_snap[63 - 8 * i -: 8]);
          for (int i = 0; i < 5; i++) begin
            want.word = chain_h[i];
            want.last = (i == int'(WORD_LAST));
            want.ovf  = ovf_seen;
            digest_q.push_back(want);
          end
          clear_state();
        end
      end
      pending_words_o <= digest_q.size();
    end
  end

endmodule

>>> tb/sv/tb_sha1_hash_engine.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Streams directed and random messages into the engine, with random gaps on
// the byte stream and random stalls on the digest stream, and lets a checker
// compare every digest word with its own SHA-1 computation.
// ---------------------------------------------------------------------------
module tb_sha1_hash_engine;

  localparam int RANDOM_REQUESTS = 350;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int pending_words;
  int mismatch_count;
  int send_idle_pct = 29;
  int recv_idle_pct = 86;
  int req_count = 0;
  int quiet_cycles = 0;

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sha1_hash_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  sha1_digest_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_last_i        (s_axis_tlast),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_last_i       (m_axis_tlast),
    .out_user_i       (m_axis_tuser),
    .pending_words_o  (pending_words),
    .mismatch_count_o (mismatch_count)
  );

  // Digest consumer with random back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles in which neither stream moves.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One byte-stream request, preceded by a random gap; returns once accepted.
  task automatic send_request(input logic [7:0] byte_val, input logic has_byte,
                              input logic is_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= byte_val;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= is_end;
    do @(posedge clk_i); while (!s_axis_tready);
    req_count++;
  endtask

  // Holds the byte stream idle until every predicted digest word is back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  // A message of random bytes, with occasional empty requests mixed in; the
  // end marker rides on the last byte or comes as a request of its own.
  task automatic send_message(input int nbytes, input bit end_alone);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(9) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(255)), 1'b1, (i == nbytes - 1) && !end_alone);
    end
    if (end_alone || nbytes == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    int nbytes;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, single-byte extremes, a short message with an
    // empty request inside, and an end marker without a byte.
    send_request(8'hFF, 1'b0, 1'b1);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hA5, 1'b1, 1'b0);
    send_request(8'h5A, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    wait_drained();

    // Random messages; lengths cluster around the padding and block edges.
    req_count = 0;
    while (req_count < RANDOM_REQUESTS) begin
      if (req_count < RANDOM_REQUESTS / 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 86;
      end else if (req_count < 2 * RANDOM_REQUESTS / 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: nbytes = $urandom_range(20);
        5, 6:          nbytes = $urandom_range(68, 52);
        7:             nbytes = $urandom_range(130, 110);
        8:             nbytes = 0;
        default:       nbytes = $urandom_range(8, 1);
      endcase
      send_message(nbytes, $urandom_range(3) == 0);
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sha1he_pkg.sv
sv/sha1_hash_engine.sv
tb/sv/sha1_digest_checker.sv
tb/sv/tb_sha1_hash_engine.sv
